// ===== rtl/core/ptz_keypad_frame_encoder_assert.svh =====
// Assertion macros for the pan/tilt keypad frame encoder.
// Included by the top level; defining NO_ASSERTIONS leaves every macro empty.
`ifndef PTZ_KEYPAD_FRAME_ENCODER_ASSERT_SVH
`define PTZ_KEYPAD_FRAME_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clock and disabled in reset.
`define PTZKF_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ptzkf assertion failed");

// Next-cycle implication, sampled on clock and disabled in reset.
`define PTZKF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ptzkf assertion failed");

`else

`define PTZKF_ASSERT_NOW(label, pre, post)
`define PTZKF_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== rtl/core/ptzkf_pkg.sv =====
// Shared constants and types of the pan/tilt keypad frame encoder.
// No dependencies; imported by the encoder and frame serialiser modules.
`default_nettype none

package ptzkf_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAMERA_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAN_SPEED      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILT_SPEED     = 2'd3;

   localparam logic [7:0]  RESET_CAMERA_ADDRESS = 8'h01;
   localparam logic [15:0] RESET_DEBOUNCE_TICKS = 16'd200;
   localparam logic [7:0]  RESET_PAN_SPEED      = 8'd32;
   localparam logic [7:0]  RESET_TILT_SPEED     = 8'd32;

   localparam logic [7:0] FRAME_SYNC     = 8'hFF;
   localparam logic [7:0] FRAME_RESERVED = 8'h00;

   // Command codes.
   localparam logic [7:0] CMD_UP_LEFT    = 8'h0C;
   localparam logic [7:0] CMD_UP_RIGHT   = 8'h0A;
   localparam logic [7:0] CMD_DOWN_LEFT  = 8'h14;
   localparam logic [7:0] CMD_DOWN_RIGHT = 8'h12;
   localparam logic [7:0] CMD_UP         = 8'h08;
   localparam logic [7:0] CMD_DOWN       = 8'h10;
   localparam logic [7:0] CMD_LEFT       = 8'h04;
   localparam logic [7:0] CMD_RIGHT      = 8'h02;

   // Byte positions within a frame.
   localparam int FRAME_LEN = 7;
   localparam logic [2:0] POS_SYNC     = 3'd0;
   localparam logic [2:0] POS_ADDRESS  = 3'd1;
   localparam logic [2:0] POS_RESERVED = 3'd2;
   localparam logic [2:0] POS_COMMAND  = 3'd3;
   localparam logic [2:0] POS_DATA1    = 3'd4;
   localparam logic [2:0] POS_DATA2    = 3'd5;
   localparam logic [2:0] POS_CHECKSUM = 3'd6;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [7:0] checksum;
   } frame_type;

endpackage

`default_nettype wire

// ===== rtl/core/ptzkf_req_if.sv =====
// Input channel of the keypad frame encoder: one button sample per word.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface ptzkf_req_if;
   logic valid;
   logic ready;
   logic up_level;
   logic down_level;
   logic left_level;
   logic right_level;
   logic ms_tick;

   modport source (
      output valid, up_level, down_level, left_level, right_level, ms_tick,
      input  ready
   );
   modport sink (
      input  valid, up_level, down_level, left_level, right_level, ms_tick,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/ptzkf_rsp_if.sv =====
// Result channel of the keypad frame encoder: one frame byte per word.
// Depends on nothing but the valid/ready handshake convention.
`default_nettype none

interface ptzkf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (
      output valid, frame_byte, frame_end,
      input  ready
   );
   modport sink (
      input  valid, frame_byte, frame_end,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/ptz_keypad_frame_encoder.sv =====
// Pan/tilt keypad frame encoder.
// req_chan carries one button sample per word: four active-low direction levels
// and a millisecond tick flag. rsp_chan carries the bytes of a seven-byte
// pan/tilt command frame, frame_end marking the checksum byte. The csr_ port
// writes camera address, debounce time and the two speeds; the user writes them
// only while the block idles, which the block does not enforce. A press is
// followed by one clearing word and then a debounce phase that counts ticks;
// once it has elapsed the same word's buttons pick the command, at most one
// frame is sent, and the block waits for all buttons to be released. The first
// byte of a frame is offered in the cycle after the word that caused it, then
// one byte per cycle while the receiver is ready; a stalled receiver holds the
// current byte. One sample word is taken every cycle, except a debounce-phase
// sample while the previous frame is being sent, which waits for it to finish.
// Reset is synchronous: the block returns to idle with a cleared tick counter,
// the registers take their defaults and any frame in flight is dropped.
// Depends on ptzkf_pkg, ptzkf_req_if, ptzkf_rsp_if and ptzkf_frame_tx.
`default_nettype none

`include "ptz_keypad_frame_encoder_assert.svh"

module ptz_keypad_frame_encoder
   import ptzkf_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   ptzkf_req_if.sink                      req_chan,
   ptzkf_rsp_if.source                    rsp_chan,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PRESSED,
      PH_DEBOUNCE,
      PH_WAIT_RELEASE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] wait_count_ff, wait_count_in;
   logic [7:0]            camera_address_ff, camera_address_in;
   logic [15:0]           debounce_ticks_ff, debounce_ticks_in;
   logic [7:0]            pan_speed_ff, pan_speed_in;
   logic [7:0]            tilt_speed_ff, tilt_speed_in;

   logic      up, down, left, right, any_pressed;
   logic      req_fire, tx_busy, frame_load, elapsed;
   logic [COUNT_BITS-1:0] count_step;
   frame_type frame;

   assign up    = !req_chan.up_level;
   assign down  = !req_chan.down_level;
   assign left  = !req_chan.left_level;
   assign right = !req_chan.right_level;
   assign any_pressed = up || down || left || right;

   // Only a debounce-phase sample can start a frame, so only that one waits.
   assign req_chan.ready = !(tx_busy && (phase_ff == PH_DEBOUNCE));
   assign req_fire = req_chan.valid && req_chan.ready;

   assign count_step = (req_chan.ms_tick && (wait_count_ff != COUNT_MAX))
                       ? wait_count_ff + 1'b1 : wait_count_ff;
   assign elapsed = (CMP_BITS'(count_step) >= CMP_BITS'(debounce_ticks_ff))
                    || (count_step == COUNT_MAX);

   assign frame_load = req_fire && (phase_ff == PH_DEBOUNCE) && elapsed && any_pressed;

   always_comb begin
      frame.address = camera_address_ff;
      frame.data1   = pan_speed_ff;
      frame.data2   = tilt_speed_ff;
      priority if (up && left) begin
         frame.command = CMD_UP_LEFT;
      end else if (up && right) begin
         frame.command = CMD_UP_RIGHT;
      end else if (down && left) begin
         frame.command = CMD_DOWN_LEFT;
      end else if (down && right) begin
         frame.command = CMD_DOWN_RIGHT;
      end else if (up) begin
         frame.command = CMD_UP;
         frame.data1   = 8'h00;
      end else if (down) begin
         frame.command = CMD_DOWN;
         frame.data1   = 8'h00;
      end else if (left) begin
         frame.command = CMD_LEFT;
         frame.data2   = 8'h00;
      end else begin
         frame.command = CMD_RIGHT;
         frame.data2   = 8'h00;
      end
      frame.checksum = frame.address + FRAME_RESERVED + frame.command
                       + frame.data1 + frame.data2;
   end

   always_comb begin
      phase_in      = phase_ff;
      wait_count_in = wait_count_ff;
      if (req_fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (any_pressed) phase_in = PH_PRESSED;
            end
            PH_PRESSED: begin
               wait_count_in = '0;
               phase_in      = PH_DEBOUNCE;
            end
            PH_DEBOUNCE: begin
               wait_count_in = count_step;
               if (elapsed) phase_in = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE: begin
               if (!any_pressed) phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      camera_address_in = camera_address_ff;
      debounce_ticks_in = debounce_ticks_ff;
      pan_speed_in      = pan_speed_ff;
      tilt_speed_in     = tilt_speed_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CAMERA_ADDRESS: camera_address_in = csr_write_data[7:0];
            CSR_DEBOUNCE_TICKS: debounce_ticks_in = csr_write_data[15:0];
            CSR_PAN_SPEED:      pan_speed_in      = csr_write_data[7:0];
            CSR_TILT_SPEED:     tilt_speed_in     = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         wait_count_ff     <= '0;
         camera_address_ff <= RESET_CAMERA_ADDRESS;
         debounce_ticks_ff <= RESET_DEBOUNCE_TICKS;
         pan_speed_ff      <= RESET_PAN_SPEED;
         tilt_speed_ff     <= RESET_TILT_SPEED;
      end else begin
         phase_ff          <= phase_in;
         wait_count_ff     <= wait_count_in;
         camera_address_ff <= camera_address_in;
         debounce_ticks_ff <= debounce_ticks_in;
         pan_speed_ff      <= pan_speed_in;
         tilt_speed_ff     <= tilt_speed_in;
      end
   end

   ptzkf_frame_tx u_frame_tx (
      .clock    (clock),
      .reset    (reset),
      .load     (frame_load),
      .frame    (frame),
      .busy     (tx_busy),
      .rsp_chan (rsp_chan)
   );

   `PTZKF_ASSERT_NOW(a_load_when_free, frame_load, !tx_busy)
   `PTZKF_ASSERT_NEXT(a_load_then_release, frame_load, phase_ff == PH_WAIT_RELEASE && tx_busy)
   `PTZKF_ASSERT_NEXT(a_pressed_clears, req_fire && phase_ff == PH_PRESSED, wait_count_ff == '0)

endmodule

`default_nettype wire

// ===== rtl/core/ptzkf_frame_tx.sv =====
// Frame serialiser: holds one captured frame and sends its seven bytes in order.
// Depends on ptzkf_pkg and the ptzkf_rsp_if channel.
`default_nettype none

module ptzkf_frame_tx
   import ptzkf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire frame_type frame,
   output logic           busy,
   ptzkf_rsp_if.source    rsp_chan
);

   logic        busy_ff, busy_in;
   logic [2:0]  pos_ff, pos_in;
   frame_type   frame_ff, frame_in;
   logic        last;

   assign last = (pos_ff == POS_CHECKSUM);
   assign busy = busy_ff;

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      frame_in = frame_ff;
      if (load) begin
         busy_in  = 1'b1;
         pos_in   = POS_SYNC;
         frame_in = frame;
      end else if (busy_ff && rsp_chan.ready) begin
         if (last) begin
            busy_in = 1'b0;
            pos_in  = POS_SYNC;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_SYNC;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      frame_ff <= frame_in;
   end

   assign rsp_chan.valid     = busy_ff;
   assign rsp_chan.frame_end = last;

   always_comb begin
      unique case (pos_ff)
         POS_SYNC:     rsp_chan.frame_byte = FRAME_SYNC;
         POS_ADDRESS:  rsp_chan.frame_byte = frame_ff.address;
         POS_RESERVED: rsp_chan.frame_byte = FRAME_RESERVED;
         POS_COMMAND:  rsp_chan.frame_byte = frame_ff.command;
         POS_DATA1:    rsp_chan.frame_byte = frame_ff.data1;
         POS_DATA2:    rsp_chan.frame_byte = frame_ff.data2;
         POS_CHECKSUM: rsp_chan.frame_byte = frame_ff.checksum;
         default:      rsp_chan.frame_byte = FRAME_SYNC;
      endcase
   end

endmodule

`default_nettype wire
